[src/acj_pkg.sv]
`timescale 1ns / 1ps

package acj_pkg;

   // sizes
   localparam int FADE_MAX     = 4096;
   localparam int ADDR_BITS    = $clog2(FADE_MAX);
   localparam int COUNT_BITS   = ADDR_BITS + 1;
   localparam int FADE_BITS    = 13;
   localparam int SAMPLE_BITS  = 16;
   localparam int POS_BITS     = 24;
   localparam int WEIGHT_FRAC  = 15;
   localparam int WEIGHT_BITS  = WEIGHT_FRAC + 2;
   localparam int Q_BITS       = WEIGHT_FRAC + 1;
   localparam int PROD_BITS    = SAMPLE_BITS + WEIGHT_BITS;
   localparam int DIV_STEPS    = Q_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

   localparam logic [FADE_BITS-1:0]   FADE_RESET = FADE_BITS'(1024);
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << WEIGHT_FRAC;
   localparam logic [POS_BITS-1:0]    POS_MAX    = '1;

   // item opcodes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // stream modes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_GAP    = 2'd1;
   localparam logic [1:0] MODE_DRAIN  = 2'd2;

   typedef struct packed {
      logic load;
      logic start_div;
      logic mul;
      logic commit;
   } acj_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_busy;
      logic commit_ok;
   } acj_status_type;

endpackage

[src/audio_chunk_crossfade_joiner.sv]
`timescale 1ns / 1ps

// Joins audio chunks, pushed one Q1.15 sample per item, into one stream. Between
// two chunks the last min(F, held) samples fade linearly to zero, F zero samples
// follow, and the next chunk's first min(F, chunk_length) samples fade in; the
// first chunk has no fade-in and the last no fade-out. F is fade_length, capped at
// 4096; writing it restarts the stream and drops held samples. After a chunk
// ends, send tick items (opcode 1): F ticks produce the gap and release the held
// tail, and after the last chunk ticks drain the line until stream_end. A sample
// pushed during a gap or drain is dropped and answered with misuse. An item that
// needs a fade weight also runs the 16-step serial weight divider; one item is in
// work at a time.

module audio_chunk_crossfade_joiner import acj_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   // input items
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic [POS_BITS-1:0]           req_chunk_length,
   input  logic                          req_last_of_chunk,
   input  logic                          req_last_chunk,
   // result items
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_stream_end,
   output logic                          rsp_misuse,
   // fade_length register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [FADE_BITS-1:0]          csr_data
);

   // command and status between sequencer and datapath
   acj_cmd_type    cmd;
   acj_status_type status;

   // sequencer: accept, decode, divide, multiply, commit
   acj_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: item capture, stream state, tail line, divider, multiplier,
   // and the result register that lets a new item in while a result waits
   acj_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_sample_in     (req_sample_in),
      .req_chunk_length  (req_chunk_length),
      .req_last_of_chunk (req_last_of_chunk),
      .req_last_chunk    (req_last_chunk),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_stream_end    (rsp_stream_end),
      .rsp_misuse        (rsp_misuse)
   );

endmodule

[src/acj_div.sv]
`timescale 1ns / 1ps

module acj_div import acj_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [ADDR_BITS-1:0] num,
   input  logic [ADDR_BITS-1:0] den,
   output logic                 busy,
   output logic [Q_BITS-1:0]    quo
);

   // restoring divide of num * 2^WEIGHT_FRAC by den, num <= den, one bit a cycle
   logic [ADDR_BITS-1:0]    rem_ff, rem_in;
   logic [Q_BITS-1:0]       bits_ff, bits_in;
   logic [Q_BITS-1:0]       quo_ff, quo_in;
   logic [ADDR_BITS-1:0]    den_ff, den_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [ADDR_BITS:0]      trial;
   logic [ADDR_BITS:0]      diff;
   logic                    ge;

   assign trial = {rem_ff, bits_ff[Q_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      bits_in = bits_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         rem_in  = {1'b0, num[ADDR_BITS-1:1]};
         bits_in = {num[0], {(Q_BITS-1){1'b0}}};
         den_in  = den;
         cnt_in  = DIV_CNT_BITS'(DIV_STEPS);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? diff[ADDR_BITS-1:0] : trial[ADDR_BITS-1:0];
         bits_in = {bits_ff[Q_BITS-2:0], 1'b0};
         quo_in  = {quo_ff[Q_BITS-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
   end

   assign busy = cnt_ff != '0;
   assign quo  = quo_ff;

endmodule

[src/acj_dp.sv]
`timescale 1ns / 1ps

module acj_dp import acj_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  acj_cmd_type                   cmd,
   output acj_status_type                status,
   input  logic                          req_opcode,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic [POS_BITS-1:0]           req_chunk_length,
   input  logic                          req_last_of_chunk,
   input  logic                          req_last_chunk,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [FADE_BITS-1:0]          csr_data,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_stream_end,
   output logic                          rsp_misuse
);

   // captured item
   logic                          op_ff;
   logic signed [SAMPLE_BITS-1:0] smp_ff;
   logic [POS_BITS-1:0]           clen_ff;
   logic                          eoc_ff;
   logic                          lastc_ff;

   // stream state
   logic [FADE_BITS-1:0]  fade_ff, fade_in;
   logic [ADDR_BITS-1:0]  head_ff, head_in;
   logic [COUNT_BITS-1:0] held_ff, held_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [COUNT_BITS-1:0] span_ff, span_in;
   logic [COUNT_BITS-1:0] idx_ff, idx_in;
   logic [COUNT_BITS-1:0] gap_ff, gap_in;
   logic [1:0]            mode_ff, mode_in;
   logic                  first_ff, first_in;

   // tail line
   logic [SAMPLE_BITS-1:0]        line_mem [FADE_MAX];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic                          wr_en;
   logic [ADDR_BITS-1:0]          wr_addr;
   logic [SAMPLE_BITS-1:0]        wr_data;

   // decode
   logic [COUNT_BITS-1:0] fade_eff;
   logic [COUNT_BITS-1:0] fin;
   logic [ADDR_BITS-1:0]  din;
   logic [ADDR_BITS-1:0]  dout;
   logic                  is_push, do_push, misuse, tick_gap, tick_drain, fzero;
   logic                  pop, fadein, fadeout, has_result, end_flag;
   logic [COUNT_BITS-1:0] held_pop;
   logic [COUNT_BITS-1:0] held_push;
   logic [COUNT_BITS-1:0] gap_dec;
   logic [POS_BITS-1:0]   pos_sat;

   // divide, weight and product
   logic                          div_busy;
   logic [Q_BITS-1:0]             quo;
   logic [WEIGHT_BITS-1:0]        weight;
   logic signed [SAMPLE_BITS-1:0] mul_op;
   logic signed [PROD_BITS-1:0]   op_ext, w_ext;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic [PROD_BITS-1:0]          bias_sum;
   logic [SAMPLE_BITS-1:0]        wsample;
   logic [SAMPLE_BITS-1:0]        out_value;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                   rsp_end_ff;
   logic                   rsp_mis_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         smp_ff   <= req_sample_in;
         clen_ff  <= req_chunk_length;
         eoc_ff   <= req_last_of_chunk;
         lastc_ff <= req_last_chunk;
      end
   end

   assign fade_eff = (32'(fade_ff) > FADE_MAX) ? COUNT_BITS'(FADE_MAX)
                                                : COUNT_BITS'(fade_ff);
   assign fin  = (clen_ff < POS_BITS'(fade_eff)) ? COUNT_BITS'(clen_ff) : fade_eff;
   assign din  = (fin > COUNT_BITS'(1)) ? ADDR_BITS'(fin - 1'b1) : ADDR_BITS'(1);
   assign dout = (span_ff > COUNT_BITS'(1)) ? ADDR_BITS'(span_ff - 1'b1)
                                            : ADDR_BITS'(1);

   assign is_push    = op_ff == OP_PUSH;
   assign do_push    = is_push && (mode_ff == MODE_NORMAL);
   assign misuse     = is_push && (mode_ff != MODE_NORMAL);
   assign tick_gap   = !is_push && (mode_ff == MODE_GAP);
   assign tick_drain = !is_push && (mode_ff == MODE_DRAIN);
   assign fzero      = fade_eff == '0;

   assign pop = ((do_push || tick_gap) && !fzero && (held_ff >= fade_eff))
             || (tick_drain && (held_ff != '0));
   assign fadein  = do_push && !first_ff && (pos_ff < POS_BITS'(fin));
   assign fadeout = pop && (idx_ff < span_ff);

   assign has_result = misuse || (do_push && fzero) || pop;
   assign end_flag   = (do_push && fzero && eoc_ff && lastc_ff)
                    || (tick_drain && (held_ff == COUNT_BITS'(1)));

   assign held_pop  = pop ? held_ff - 1'b1 : held_ff;
   assign held_push = held_pop + 1'b1;
   assign gap_dec   = (gap_ff != '0) ? gap_ff - 1'b1 : gap_ff;
   assign pos_sat   = (pos_ff != POS_MAX) ? pos_ff + 1'b1 : pos_ff;

   acj_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.start_div),
      .num   (fadein ? pos_ff[ADDR_BITS-1:0] : idx_ff[ADDR_BITS-1:0]),
      .den   (fadein ? din : dout),
      .busy  (div_busy),
      .quo   (quo)
   );

   // unfaded values go through with weight one, which is exact
   assign weight = fadein  ? {1'b0, quo}
                 : fadeout ? WEIGHT_ONE - {1'b0, quo}
                 :           WEIGHT_ONE;
   assign mul_op = do_push ? smp_ff : rd_data_ff;
   assign op_ext = PROD_BITS'(mul_op);
   assign w_ext  = $signed(PROD_BITS'(weight));

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= op_ext * w_ext;
      end
   end

   // shift right truncating toward zero
   assign bias_sum = prod_ff + (prod_ff[PROD_BITS-1] ? PROD_BITS'(WEIGHT_ONE - 1'b1)
                                                     : PROD_BITS'(0));
   assign wsample  = bias_sum[WEIGHT_FRAC +: SAMPLE_BITS];

   assign out_value = misuse                ? '0
                    : (do_push && !fzero)   ? rd_data_ff
                    :                         wsample;

   assign wr_en   = cmd.commit && ((do_push && !fzero) || tick_gap);
   assign wr_addr = head_ff + held_ff[ADDR_BITS-1:0];
   assign wr_data = do_push ? wsample : '0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= line_mem[head_ff];
   end

   always_comb begin
      fade_in  = fade_ff;
      head_in  = head_ff;
      held_in  = held_ff;
      pos_in   = pos_ff;
      span_in  = span_ff;
      idx_in   = idx_ff;
      gap_in   = gap_ff;
      mode_in  = mode_ff;
      first_in = first_ff;
      if (csr_valid && csr_ready) begin
         fade_in  = csr_data;
         head_in  = '0;
         held_in  = '0;
         pos_in   = '0;
         span_in  = '0;
         idx_in   = '0;
         gap_in   = '0;
         mode_in  = MODE_NORMAL;
         first_in = 1'b1;
      end else if (cmd.commit) begin
         if (pop) begin
            head_in = head_ff + 1'b1;
         end
         if (fadeout) begin
            idx_in = idx_ff + 1'b1;
         end
         if (do_push && fzero) begin
            if (eoc_ff && lastc_ff) begin
               head_in  = '0;
               held_in  = '0;
               pos_in   = '0;
               span_in  = '0;
               idx_in   = '0;
               gap_in   = '0;
               mode_in  = MODE_NORMAL;
               first_in = 1'b1;
            end else if (eoc_ff) begin
               first_in = 1'b0;
               pos_in   = '0;
            end else begin
               pos_in = pos_sat;
            end
         end else if (do_push) begin
            held_in = held_push;
            pos_in  = pos_sat;
            if (eoc_ff) begin
               idx_in = '0;
               if (lastc_ff) begin
                  mode_in = MODE_DRAIN;
                  span_in = '0;
               end else begin
                  mode_in = MODE_GAP;
                  span_in = held_push;
                  gap_in  = fade_eff;
               end
            end
         end else if (tick_gap) begin
            held_in = held_push;
            gap_in  = gap_dec;
            if (gap_dec == '0) begin
               mode_in  = MODE_NORMAL;
               first_in = 1'b0;
               pos_in   = '0;
               span_in  = '0;
               idx_in   = '0;
            end
         end else if (tick_drain) begin
            held_in = held_pop;
            if (held_ff <= COUNT_BITS'(1)) begin
               head_in  = '0;
               held_in  = '0;
               pos_in   = '0;
               span_in  = '0;
               idx_in   = '0;
               gap_in   = '0;
               mode_in  = MODE_NORMAL;
               first_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_ff  <= FADE_RESET;
         head_ff  <= '0;
         held_ff  <= '0;
         pos_ff   <= '0;
         span_ff  <= '0;
         idx_ff   <= '0;
         gap_ff   <= '0;
         mode_ff  <= MODE_NORMAL;
         first_ff <= 1'b1;
      end else begin
         fade_ff  <= fade_in;
         head_ff  <= head_in;
         held_ff  <= held_in;
         pos_ff   <= pos_in;
         span_ff  <= span_in;
         idx_ff   <= idx_in;
         gap_ff   <= gap_in;
         mode_ff  <= mode_in;
         first_ff <= first_in;
      end
   end

   assign rsp_valid_in = (cmd.commit && has_result) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && has_result) begin
         rsp_sample_ff <= out_value;
         rsp_end_ff    <= end_flag;
         rsp_mis_ff    <= misuse;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_stream_end = rsp_end_ff;
   assign rsp_misuse     = rsp_mis_ff;

   assign status.need_div  = fadein || fadeout;
   assign status.div_busy  = div_busy;
   assign status.commit_ok = !has_result || !rsp_valid_ff || !rsp_stall;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= fade_eff)
      else $error("tail line holds more than the fade length");

   a_mode_needs_fade: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_NORMAL) |-> (fade_eff != '0))
      else $error("gap or drain with zero fade length");

   a_fadeout_index: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= span_ff)
      else $error("fade-out index beyond fade-out span");

   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && has_result) |=> rsp_valid_ff)
      else $error("committed result not presented");

endmodule

[src/acj_ctrl.sv]
`timescale 1ns / 1ps

module acj_ctrl import acj_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           csr_ready,
   input  acj_status_type status,
   output acj_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DECODE   = 3'd1;
   localparam logic [2:0] ST_DIVIDE   = 3'd2;
   localparam logic [2:0] ST_MULTIPLY = 3'd3;
   localparam logic [2:0] ST_COMMIT   = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.need_div) begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_MULTIPLY;
            end
         end
         ST_DIVIDE: begin
            if (!status.div_busy) begin
               state_in = ST_MULTIPLY;
            end
         end
         ST_MULTIPLY: begin
            cmd.mul  = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.commit_ok) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = state_ff == ST_IDLE;

endmodule

[bench/tb_audio_chunk_crossfade_joiner.sv]
`timescale 1ns / 1ps

module tb_audio_chunk_crossfade_joiner;
   import acj_pkg::*;

   localparam int     IDLE_LIMIT    = 4000;   // cycles with no handshake at all
   localparam int     SETTLE_CYCLES = 40;     // covers the weighted item, which runs the divider
   localparam int     LONG_HOLD     = 400;    // receiver hold-off for backpressure
   localparam int     RANDOM_ITEMS  = 300;
   localparam longint UNITY         = longint'(WEIGHT_ONE);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] pcm;
      logic                          stream_end;
      logic                          misuse;
   } joined_sample_type;

   // predicts the joined stream and checks the block's output against it
   class crossfade_board_type;
      joined_sample_type             expected_out[$];
      logic signed [SAMPLE_BITS-1:0] tail_mem [FADE_MAX];
      int unsigned                   head_ptr, held, position;
      int unsigned                   fo_span, fo_idx, gap_left;
      logic [1:0]                    stream_mode;
      bit                            first_chunk;
      logic [FADE_BITS-1:0]          fade_reg;
      int unsigned                   mismatch_count;

      function new();
         fade_reg       = FADE_RESET;
         mismatch_count = 0;
         restart();
      endfunction

      function void restart();
         head_ptr    = 0;
         held        = 0;
         position    = 0;
         fo_span     = 0;
         fo_idx      = 0;
         gap_left    = 0;
         stream_mode = MODE_NORMAL;
         first_chunk = 1'b1;
      endfunction

      function void configure(logic [FADE_BITS-1:0] value);
         fade_reg = value;
         restart();
      endfunction

      function int unsigned fade();
         return (fade_reg > FADE_MAX) ? FADE_MAX : fade_reg;
      endfunction

      function int pending();
         return expected_out.size();
      endfunction

      // q1.15 product, truncated toward zero
      function longint weighted(longint v, longint w);
         longint p;
         p = v * w;
         if (p < 0)
            return -((-p) >>> WEIGHT_FRAC);
         return p >>> WEIGHT_FRAC;
      endfunction

      function void push_line(longint v);
         tail_mem[ADDR_BITS'((head_ptr + held) % FADE_MAX)] = v[SAMPLE_BITS-1:0];
         held++;
      endfunction

      // oldest held sample, faded out while it belongs to the tail
      function longint pop_line();
         longint v;
         longint d;
         v        = tail_mem[ADDR_BITS'(head_ptr)];
         head_ptr = (head_ptr + 1) % FADE_MAX;
         held--;
         if (fo_idx < fo_span) begin
            d = (fo_span > 1) ? fo_span - 1 : 1;
            v = weighted(v, UNITY - (longint'(fo_idx) * UNITY) / d);
            fo_idx++;
         end
         return v;
      endfunction

      function void expect_out(longint v, bit se, bit mis);
         joined_sample_type e;
         e.pcm        = v[SAMPLE_BITS-1:0];
         e.stream_end = se;
         e.misuse     = mis;
         expected_out.insert(expected_out.size(), e);
      endfunction

      function void predict_item(logic op, logic signed [SAMPLE_BITS-1:0] pcm,
                                 logic [POS_BITS-1:0] clen, logic eoc, logic lastc);
         int unsigned f;
         int unsigned fin;
         longint      d;
         longint      v;
         f = fade();
         if (op == OP_PUSH) begin
            if (stream_mode != MODE_NORMAL) begin
               expect_out(0, 1'b0, 1'b1);
               return;
            end
            v   = pcm;
            fin = (clen < f) ? clen : f;
            if (!first_chunk && position < fin) begin
               d = (fin > 1) ? fin - 1 : 1;
               v = weighted(v, (longint'(position) * UNITY) / d);
            end
            if (position < POS_MAX)
               position++;
            if (f == 0) begin
               expect_out(v, eoc && lastc, 1'b0);
               if (eoc && lastc) begin
                  restart();
               end else if (eoc) begin
                  first_chunk = 1'b0;
                  position    = 0;
               end
               return;
            end
            if (held >= f)
               expect_out(pop_line(), 1'b0, 1'b0);
            if (held < FADE_MAX)
               push_line(v);
            if (eoc) begin
               fo_idx = 0;
               if (lastc) begin
                  stream_mode = MODE_DRAIN;
                  fo_span     = 0;
               end else begin
                  stream_mode = MODE_GAP;
                  fo_span     = held;
                  gap_left    = f;
               end
            end
         end else if (stream_mode == MODE_GAP) begin
            if (f > 0 && held >= f)
               expect_out(pop_line(), 1'b0, 1'b0);
            if (held < FADE_MAX)
               push_line(0);
            if (gap_left > 0)
               gap_left--;
            if (gap_left == 0) begin
               stream_mode = MODE_NORMAL;
               first_chunk = 1'b0;
               position    = 0;
               fo_span     = 0;
               fo_idx      = 0;
            end
         end else if (stream_mode == MODE_DRAIN) begin
            if (held == 0) begin
               restart();
               return;
            end
            v = pop_line();
            if (held == 0) begin
               expect_out(v, 1'b1, 1'b0);
               restart();
            end else begin
               expect_out(v, 1'b0, 1'b0);
            end
         end
      endfunction

      function void compare_output(logic signed [SAMPLE_BITS-1:0] pcm, logic se, logic mis);
         joined_sample_type e;
         if (expected_out.size() == 0) begin
            $error("unexpected output item: sample_out %0d stream_end %0b misuse %0b",
                   pcm, se, mis);
            mismatch_count++;
            return;
         end
         e = expected_out.pop_front();
         if (pcm !== e.pcm) begin
            $error("sample_out expected %0d actual %0d", e.pcm, pcm);
            mismatch_count++;
         end
         if (se !== e.stream_end) begin
            $error("stream_end expected %0b actual %0b", e.stream_end, se);
            mismatch_count++;
         end
         if (mis !== e.misuse) begin
            $error("misuse expected %0b actual %0b", e.misuse, mis);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                          clock             = 1'b0;
   logic                          reset             = 1'b1;
   logic                          req_valid         = 1'b0;
   logic                          req_stall;
   logic                          req_opcode        = OP_PUSH;
   logic signed [SAMPLE_BITS-1:0] req_sample_in     = '0;
   logic [POS_BITS-1:0]           req_chunk_length  = '0;
   logic                          req_last_of_chunk = 1'b0;
   logic                          req_last_chunk    = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall         = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          rsp_stream_end;
   logic                          rsp_misuse;
   logic                          csr_valid         = 1'b0;
   logic                          csr_ready;
   logic [FADE_BITS-1:0]          csr_data          = '0;

   crossfade_board_type board = new();

   int unsigned items_sent   = 0;
   int unsigned idle_cycles  = 0;
   bit          gap_free     = 1'b0;   // sender offers back to back
   bit          hold_request = 1'b0;   // asks the receiver for one long hold-off
   int          hold_left    = 0;
   bit          hold_now     = 1'b0;

   audio_chunk_crossfade_joiner DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_sample_in     (req_sample_in),
      .req_chunk_length  (req_chunk_length),
      .req_last_of_chunk (req_last_of_chunk),
      .req_last_chunk    (req_last_chunk),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_stream_end    (rsp_stream_end),
      .rsp_misuse        (rsp_misuse),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   always #4 clock = ~clock;

   // result side: check accepted items, then pick the next stall segment
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.compare_output(rsp_sample_out, rsp_stream_end, rsp_misuse);
      if (hold_left == 0) begin
         if (hold_request) begin
            // long hold-off so the block fills up and stalls its input
            hold_request = 1'b0;
            hold_now     = 1'b1;
            hold_left    = LONG_HOLD;
         end else if ($urandom_range(0, 2) == 0) begin
            hold_now  = 1'b0;
            hold_left = $urandom_range(5, 40);
         end else begin
            hold_now  = 1'b1;
            hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(1, 3);
         end
      end
      hold_left--;
      rsp_stall <= hold_now;
   end

   // watchdog: any handshake restarts the count
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("audio_chunk_crossfade_joiner verification failed");
         $finish;
      end
   end

   function automatic logic signed [SAMPLE_BITS-1:0] rand_pcm();
      case ($urandom_range(0, 15))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // offer one item and hold it until accepted; valid only drops ahead of a gap
   task automatic send_item(input logic op, input logic signed [SAMPLE_BITS-1:0] pcm,
                            input logic [POS_BITS-1:0] clen, input logic eoc,
                            input logic lastc);
      int gap;
      int roll;
      gap = 0;
      if (!gap_free) begin
         roll = $urandom_range(0, 9);
         if (roll == 9)
            gap = $urandom_range(8, 40);
         else if (roll >= 6)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_sample_in     <= pcm;
      req_chunk_length  <= clen;
      req_last_of_chunk <= eoc;
      req_last_chunk    <= lastc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.predict_item(op, pcm, clen, eoc, lastc);
      items_sent++;
   endtask

   // tick item; the other fields carry junk
   task automatic send_tick();
      send_item(OP_TICK, SAMPLE_BITS'($urandom), POS_BITS'($urandom),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // one chunk of len samples; noisy adds stray ticks and last_chunk flags
   task automatic send_chunk(input int len, input logic [POS_BITS-1:0] clen,
                             input logic lastc, input bit noisy);
      logic eoc;
      for (int i = 0; i < len; i++) begin
         eoc = (i == len - 1);
         if (noisy && $urandom_range(0, 19) == 0)
            send_tick();
         send_item(OP_PUSH, rand_pcm(), clen, eoc,
                   eoc ? lastc : (lastc | (noisy && $urandom_range(0, 7) == 0)));
      end
   endtask

   // tick through a gap or a drain; noisy drops in misplaced samples
   task automatic flush_stream(input bit noisy);
      while (board.stream_mode != MODE_NORMAL) begin
         if (noisy && $urandom_range(0, 9) == 0)
            send_item(OP_PUSH, rand_pcm(), POS_BITS'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         else
            send_tick();
      end
   endtask

   // sender pauses until every expected item is out and the block is quiet
   task automatic settle_stream();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_fade(input logic [FADE_BITS-1:0] value);
      settle_stream();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.configure(value);
   endtask

   // well-formed stream of random chunks, sometimes cut off partway
   task automatic random_stream(output bit aborted);
      int                  chunks;
      int                  len;
      int                  f;
      int                  pick;
      logic [POS_BITS-1:0] clen;
      aborted = 1'b0;
      f       = board.fade();
      chunks  = $urandom_range(1, 4);
      for (int c = 0; c < chunks; c++) begin
         len  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2 * f + 6)
                                            : $urandom_range(1, f + 3);
         pick = $urandom_range(0, 31);
         clen = POS_BITS'(len);
         if (pick == 0)
            clen = '0;
         else if (pick == 1)
            clen = POS_MAX;
         else if (pick < 4)
            clen = POS_BITS'($urandom);
         send_chunk(len, clen, c == chunks - 1, 1'b1);
         if ($urandom_range(0, 24) == 0) begin
            aborted = 1'b1;
            return;
         end
         flush_stream(1'b1);
      end
   endtask

   initial begin
      bit          aborted;
      bit          first_phase;
      int          f;
      int          streams;
      int unsigned start;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset fade length: short final chunk, drains unfaded
      send_chunk(3, 24'd3, 1'b1, 1'b0);
      flush_stream(1'b0);

      // fade length 3: full-scale samples through fade-out, gap and fade-in
      write_fade(13'd3);
      send_tick();   // tick in normal mode is ignored
      send_item(OP_PUSH, 16'sh7FFF, 24'd4, 1'b0, 1'b0);
      send_item(OP_PUSH, 16'sh8000, 24'd4, 1'b0, 1'b0);
      send_item(OP_PUSH, 16'shFFFF, 24'd4, 1'b0, 1'b0);
      send_item(OP_PUSH, 16'sh0001, 24'd4, 1'b1, 1'b0);
      send_tick();
      send_item(OP_PUSH, 16'sh4000, 24'd4, 1'b0, 1'b0);   // dropped during gap
      flush_stream(1'b0);
      // chunk longer than its stated length: fade-in stops early
      send_chunk(4, 24'd2, 1'b0, 1'b0);
      flush_stream(1'b0);
      send_chunk(3, POS_MAX, 1'b1, 1'b0);
      send_item(OP_PUSH, 16'sh7FFF, 24'd3, 1'b1, 1'b1);   // dropped during drain
      flush_stream(1'b0);

      // zero fade length: straight through, zero chunk length too
      write_fade(13'd0);
      send_chunk(2, 24'd2, 1'b0, 1'b0);
      send_chunk(2, 24'd0, 1'b1, 1'b0);

      // fade length 1: one-sample fades give zero fade-in weight
      write_fade(13'd1);
      send_chunk(2, 24'd2, 1'b0, 1'b0);
      flush_stream(1'b0);
      send_chunk(2, 24'd2, 1'b1, 1'b0);
      flush_stream(1'b0);

      // largest fade length: partly filled line, then drain it all
      write_fade(13'd4096);
      gap_free = 1'b1;
      send_chunk(40, 24'd40, 1'b1, 1'b0);
      flush_stream(1'b0);
      gap_free = 1'b0;

      // register above the cap, then a write in the middle of a gap
      write_fade(13'h1FFF);
      send_chunk(5, 24'd5, 1'b0, 1'b0);
      repeat (6) send_tick();
      send_item(OP_PUSH, rand_pcm(), 24'd5, 1'b0, 1'b0);

      // random phases, each with its own fade length
      start       = items_sent;
      first_phase = 1'b1;
      while (items_sent - start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       f = 0;
            1:       f = $urandom_range(9, 20);
            default: f = $urandom_range(1, 8);
         endcase
         streams = $urandom_range(1, 3);
         if (first_phase) begin
            // backpressure phase: sender keeps offering during the long hold-off
            f        = 2;
            streams  = 8;
            gap_free = 1'b1;
         end
         write_fade(FADE_BITS'(f));
         if (first_phase)
            hold_request = 1'b1;
         for (int s = 0; s < streams; s++) begin
            random_stream(aborted);
            if (aborted)
               break;
         end
         gap_free    = 1'b0;
         first_phase = 1'b0;
      end

      settle_stream();
      if (board.mismatch_count == 0 && board.pending() == 0)
         $display("audio_chunk_crossfade_joiner verification clean");
      else
         $display("audio_chunk_crossfade_joiner verification failed");
      $finish;
   end

endmodule
